// ===== hdl/sprle_pkg.sv =====
// Package for the split-plane run-length image decoder.
// Holds the parse phase and sequencer types, status codes and register indexes.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package sprle_pkg;

  // Where the parser stands within a line of the compressed stream.
  typedef enum logic [2:0] {
    PH_LEN_HI = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LOW    = 3'd2,
    PH_COUNT  = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  // Result sequencer: store read, then output register load.
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_READ = 2'd1,
    SEQ_OUT  = 2'd2
  } seq_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OVERFLOW   = 3'd1;
  localparam logic [2:0] ST_SHORT_LINE = 3'd2;
  localparam logic [2:0] ST_ODD_PAIR   = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT = 2'd1;

  localparam int unsigned LINE_BUF_BYTES = 10 * 1024;
  localparam int unsigned BYTE_BASE      = 256;

  localparam logic [12:0] LINE_WIDTH_RESET = 13'd1024;
  localparam logic [12:0] LINE_COUNT_RESET = 13'd1024;

endpackage

`default_nettype wire

// ===== hdl/split_plane_rle_image_decoder.sv =====
// Top level of the split-plane run-length image decoder.
// Parser, four-bank low-byte line store, result sequencer and output register.
// Depends on sprle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a byte stream of 16-bit image lines: each line is a big-endian length
// word, line_width raw low bytes kept in a line store, then (count, value) pairs
// that expand the high bytes. Each byte is parsed as it is accepted; each result it
// causes then passes through the sequencer, which reads the four interleaved store
// banks and then loads the output register. A run of n pixels yields ceil(n/4)
// results, a byte that closes a line without placing a pixel yields one status-only
// result, and any other byte yields none; the sequencer waits while the output is
// stalled. in_ready is low while results of
// a byte are still being produced; a finished result may wait in the output
// register while the next byte is taken. The store needs no clearing pass.
module split_plane_rle_image_decoder #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_LINES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel_a,
  output logic [15:0] pixel_b,
  output logic [15:0] pixel_c,
  output logic [15:0] pixel_d,
  output logic [2:0]  pixel_count,
  output logic [11:0] first_column,
  output logic [11:0] row_index,
  output logic        end_of_line,
  output logic        end_of_image,
  output logic [2:0]  status,
  output logic        last_of_run
);
  import sprle_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_LINES + 1);
  localparam int BD  = (MAX_WIDTH + 3) / 4;
  localparam int BAW = $clog2(BD);

  // Configuration registers.
  logic [12:0] line_width;
  logic [12:0] line_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      line_count <= LINE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LINE_WIDTH) line_width <= cfg_data;
      if (cfg_index == REG_LINE_COUNT) line_count <= cfg_data;
    end
  end

  logic [WW-1:0] width_eff;
  logic [RW-1:0] lines_eff;

  always_comb begin
    if (line_width == 13'd0)                     width_eff = WW'(1);
    else if (32'(line_width) > 32'(MAX_WIDTH))   width_eff = WW'(MAX_WIDTH);
    else                                         width_eff = WW'(line_width);
    if (line_count == 13'd0)                     lines_eff = RW'(1);
    else if (32'(line_count) > 32'(MAX_LINES))   lines_eff = RW'(MAX_LINES);
    else                                         lines_eff = RW'(line_count);
  end

  // Parser state.
  phase_t        phase, phase_next;
  logic [7:0]    length_high, length_high_next;
  logic [15:0]   line_bytes_left, line_bytes_left_next;
  logic [WW-1:0] column, column_next;
  logic [WW-1:0] low_bytes_seen, low_bytes_seen_next;
  logic [RW-1:0] row, row_next;
  logic [7:0]    run_count, run_count_next;
  logic [2:0]    line_error, line_error_next;

  // Sequencer and the job it works through.
  seq_t          seq, seq_next;
  logic [7:0]    job_val;
  logic [WW-1:0] job_col;
  logic [7:0]    job_cnt;
  logic [6:0]    job_nres;
  logic [5:0]    job_r;
  logic          job_ends;
  logic          job_eoi;
  logic [2:0]    job_status;
  logic [RW-1:0] job_row;

  logic          in_accept;
  logic          out_load;

  // Step decode, valid in the cycle a byte is accepted.
  logic          ends;
  logic          last_line;
  logic [7:0]    emit_cnt;
  logic [WW-1:0] avail;
  logic [15:0]   line_len;
  logic [6:0]    nres;
  logic          store_we;

  assign in_accept = in_valid && in_ready;

  always_comb begin
    phase_next           = phase;
    length_high_next     = length_high;
    line_bytes_left_next = line_bytes_left;
    column_next          = column;
    low_bytes_seen_next  = low_bytes_seen;
    row_next             = row;
    run_count_next       = run_count;
    line_error_next      = line_error;
    ends                 = 1'b0;
    emit_cnt             = 8'd0;
    avail                = '0;
    line_len             = {length_high, data_byte};
    store_we             = 1'b0;

    case (phase)
      PH_LEN_HI: begin
        length_high_next = data_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        column_next         = '0;
        low_bytes_seen_next = '0;
        run_count_next      = 8'd0;
        line_error_next     = ST_OK;
        if (line_len < 16'd2) begin
          line_error_next      = ST_BAD_LENGTH;
          line_bytes_left_next = 16'd0;
          ends                 = 1'b1;
        end else begin
          line_bytes_left_next = line_len - 16'd2;
          if (32'(line_len) > LINE_BUF_BYTES) line_error_next = ST_BAD_LENGTH;
          phase_next = PH_LOW;
          if (line_len == 16'd2) ends = 1'b1;
        end
      end
      default: begin
        if (phase == PH_LOW && low_bytes_seen < width_eff) begin
          store_we            = 1'b1;
          low_bytes_seen_next = WW'(32'(low_bytes_seen) + 32'd1);
          if (low_bytes_seen_next >= width_eff) phase_next = PH_COUNT;
        end else if (phase == PH_VALUE) begin
          avail = (width_eff > column) ? (width_eff - column) : '0;
          if (32'(run_count) < 32'(avail)) emit_cnt = run_count;
          else                             emit_cnt = 8'(avail);
          if (run_count > emit_cnt && ST_OVERFLOW > line_error_next) begin
            line_error_next = ST_OVERFLOW;
          end
          column_next = WW'(32'(column) + 32'(emit_cnt));
          phase_next  = PH_COUNT;
        end else begin
          run_count_next = data_byte;
          phase_next     = PH_VALUE;
        end
        if (line_bytes_left != 16'd0) line_bytes_left_next = line_bytes_left - 16'd1;
        if (line_bytes_left_next == 16'd0) ends = 1'b1;
      end
    endcase

    if (ends) begin
      if (phase_next == PH_VALUE && ST_ODD_PAIR > line_error_next) begin
        line_error_next = ST_ODD_PAIR;
      end
      if (column_next < width_eff && ST_SHORT_LINE > line_error_next) begin
        line_error_next = ST_SHORT_LINE;
      end
    end

    nres = 7'((9'(emit_cnt) + 9'd3) >> 2);
    if (ends && nres == 7'd0) nres = 7'd1;

    last_line = (32'(row) + 32'd1) >= 32'(lines_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_HI;
      length_high     <= 8'd0;
      line_bytes_left <= 16'd0;
      column          <= '0;
      low_bytes_seen  <= '0;
      row             <= '0;
      run_count       <= 8'd0;
      line_error      <= ST_OK;
    end else if (in_accept) begin
      length_high <= length_high_next;
      if (ends) begin
        // Line finished: back to waiting for a length word.
        phase           <= PH_LEN_HI;
        line_bytes_left <= 16'd0;
        column          <= '0;
        low_bytes_seen  <= '0;
        run_count       <= 8'd0;
        line_error      <= ST_OK;
        row             <= last_line ? '0 : RW'(32'(row) + 32'd1);
      end else begin
        phase           <= phase_next;
        line_bytes_left <= line_bytes_left_next;
        column          <= column_next;
        low_bytes_seen  <= low_bytes_seen_next;
        run_count       <= run_count_next;
        line_error      <= line_error_next;
        row             <= row_next;
      end
    end
  end

  // Job capture for the result sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_r <= 6'd0;
    end else if (in_accept) begin
      job_r <= 6'd0;
    end else if (out_load) begin
      job_r <= job_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_val    <= data_byte;
      job_col    <= column;
      job_cnt    <= emit_cnt;
      job_nres   <= nres;
      job_ends   <= ends;
      job_eoi    <= ends && last_line;
      job_status <= line_error_next;
      job_row    <= row;
    end
  end

  // Result being built.
  logic [7:0]    done;
  logic [7:0]    res_left;
  logic [2:0]    res_cnt;
  logic [WW-1:0] base;
  logic          res_last;

  always_comb begin
    done     = {job_r, 2'b00};
    res_left = (job_cnt > done) ? (job_cnt - done) : 8'd0;
    res_cnt  = (res_left > 8'd4) ? 3'd4 : 3'(res_left);
    base     = WW'(32'(job_col) + 32'(done));
    res_last = (7'(job_r) + 7'd1) == job_nres;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) seq <= SEQ_IDLE;
    else     seq <= seq_next;
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_IDLE: begin
        if (in_accept && nres != 7'd0) seq_next = SEQ_READ;
      end
      SEQ_READ: seq_next = SEQ_OUT;
      SEQ_OUT: begin
        if (out_load) seq_next = res_last ? SEQ_IDLE : SEQ_READ;
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (seq)
      SEQ_IDLE: in_ready = 1'b1;
      SEQ_READ: in_ready = 1'b0;
      SEQ_OUT:  out_load = !out_valid || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  // Line store in four banks interleaved by column, so that one read of all banks
  // serves four consecutive columns.
  logic [7:0]     rd_data [4];
  logic [BAW-1:0] wr_addr;

  assign wr_addr = BAW'(32'(low_bytes_seen) >> 2);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]     mem [BD];
    logic [7:0]     rd_byte;
    logic [1:0]     ofs;
    logic [31:0]    rd_row;
    logic           rd_ok;
    logic [BAW-1:0] rd_addr;

    always_comb begin
      ofs     = 2'(k) - base[1:0];
      rd_row  = (32'(base) + 32'(ofs)) >> 2;
      rd_ok   = rd_row < 32'(BD);
      rd_addr = BAW'(rd_row);
    end

    always_ff @(posedge clk) begin
      if (in_accept && store_we && low_bytes_seen[1:0] == 2'(k)) begin
        mem[wr_addr] <= data_byte;
      end
      if (seq == SEQ_READ && rd_ok) begin
        rd_byte <= mem[rd_addr];
      end
    end

    assign rd_data[k] = rd_byte;
  end

  // Output register.
  logic [15:0] pix [4];
  logic [31:0] base_ext;
  logic [31:0] row_ext;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < res_cnt) pix[j] = {job_val, rd_data[2'(base[1:0] + 2'(j))]};
      else                 pix[j] = 16'd0;
    end
    base_ext = 32'(base);
    row_ext  = 32'(job_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_a      <= pix[0];
      pixel_b      <= pix[1];
      pixel_c      <= pix[2];
      pixel_d      <= pix[3];
      pixel_count  <= res_cnt;
      first_column <= (res_cnt != 3'd0) ? base_ext[11:0] : 12'd0;
      row_index    <= row_ext[11:0];
      end_of_line  <= job_ends && res_last;
      end_of_image <= job_eoi && res_last;
      status       <= job_status;
      last_of_run  <= res_last;
    end
  end

`ifndef SYNTH
  a_load_in_job: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (7'(job_r) < job_nres))
    else $error("result loaded beyond the results of its byte");

  a_eol_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_line) |-> last_of_run)
    else $error("end of line on a result that is not the last of its byte");

  a_status_only_at_eol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_count == 3'd0) |-> end_of_line)
    else $error("empty result that does not close a line");

  a_eoi_has_eol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_image) |-> end_of_line)
    else $error("end of image without end of line");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (seq == SEQ_READ) |=> (seq == SEQ_OUT && !in_ready))
    else $error("sequencer left the store read without producing a result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the split-plane run-length image decoder.
// Holds a line-decode scoreboard class and the stimulus, byte and config drivers.
// Depends on sprle_pkg and split_plane_rle_image_decoder.
`timescale 1ns / 1ps

module testbench;
  import sprle_pkg::*;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_LINES = 4096;

  typedef logic [7:0] bytes_t[$];

  typedef struct packed {
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic [15:0] pixel_c;
    logic [15:0] pixel_d;
    logic [2:0]  pixel_count;
    logic [11:0] first_column;
    logic [11:0] row_index;
    logic        end_of_line;
    logic        end_of_image;
    logic [2:0]  status;
    logic        last_of_run;
  } result_t;

  // Tracks the decoder's line state and keeps the pixel beats still owed by the block.
  class line_decode_scoreboard;
    logic [12:0] width_reg;
    logic [12:0] count_reg;
    phase_t      phase;
    logic [7:0]  len_high;
    logic [15:0] bytes_left;
    logic [12:0] column;
    logic [12:0] low_seen;
    logic [11:0] row;
    logic [7:0]  run_count;
    logic [2:0]  line_err;
    logic [7:0]  low_store[MAX_WIDTH];
    result_t     expected_pixels[$];
    int unsigned failures;

    function new();
      width_reg = LINE_WIDTH_RESET;
      count_reg = LINE_COUNT_RESET;
      phase = PH_LEN_HI;
      len_high = '0;
      bytes_left = '0;
      column = '0;
      low_seen = '0;
      row = '0;
      run_count = '0;
      line_err = ST_OK;
      failures = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [12:0] value);
      if (idx == REG_LINE_WIDTH) width_reg = value;
      else if (idx == REG_LINE_COUNT) count_reg = value;
    endfunction

    function void flag_error(logic [2:0] code);
      if (code > line_err) line_err = code;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    // Advances the line state by one accepted byte and queues the beats it causes.
    function void take_byte(logic [7:0] b);
      int unsigned w, lines, len, avail, run_len, run_col, nres, done, cnt;
      logic [7:0]  run_val;
      logic [15:0] px[4];
      bit          ends;
      result_t     res;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      lines = count_reg;
      if (lines < 1) lines = 1;
      if (lines > MAX_LINES) lines = MAX_LINES;
      run_len = 0;
      run_col = 0;
      run_val = '0;
      ends = 1'b0;

      if (phase == PH_LEN_HI) begin
        len_high = b;
        phase = PH_LEN_LO;
        return;
      end else if (phase == PH_LEN_LO) begin
        len = {len_high, b};
        column = '0;
        low_seen = '0;
        run_count = '0;
        line_err = ST_OK;
        if (len < 2) begin
          line_err = ST_BAD_LENGTH;
          bytes_left = '0;
          ends = 1'b1;
        end else begin
          bytes_left = 16'(len - 2);
          if (len > LINE_BUF_BYTES) line_err = ST_BAD_LENGTH;
          phase = PH_LOW;
          if (bytes_left == 0) ends = 1'b1;
        end
      end else begin
        if (phase == PH_LOW && low_seen < w) begin
          low_store[low_seen] = b;
          low_seen++;
          if (low_seen >= w) phase = PH_COUNT;
        end else if (phase == PH_VALUE) begin
          avail = (w > column) ? w - column : 0;
          run_col = column;
          run_len = (run_count < avail) ? run_count : avail;
          if (run_count > run_len) flag_error(ST_OVERFLOW);
          column = 13'(column + run_len);
          run_val = b;
          phase = PH_COUNT;
        end else begin
          // A byte in the low phase past the width is taken as a run count too.
          run_count = b;
          phase = PH_VALUE;
        end
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) ends = 1'b1;
      end

      if (ends) begin
        if (phase == PH_VALUE) flag_error(ST_ODD_PAIR);
        if (column < w) flag_error(ST_SHORT_LINE);
      end

      nres = (run_len + 3) / 4;
      if (ends && nres == 0) nres = 1;
      for (int r = 0; r < nres; r++) begin
        done = 4 * r;
        cnt = (run_len > done) ? run_len - done : 0;
        if (cnt > 4) cnt = 4;
        for (int j = 0; j < 4; j++)
          px[j] = (j < cnt) ? {run_val, low_store[run_col + done + j]} : 16'h0000;
        res.pixel_a = px[0];
        res.pixel_b = px[1];
        res.pixel_c = px[2];
        res.pixel_d = px[3];
        res.pixel_count = 3'(cnt);
        res.first_column = (cnt != 0) ? 12'(run_col + done) : 12'h000;
        res.row_index = row;
        res.end_of_line = ends && (r + 1 == nres);
        res.end_of_image = ends && (r + 1 == nres) && (int'(row) + 1 >= lines);
        res.status = line_err;
        res.last_of_run = (r + 1 == nres);
        expected_pixels.push_back(res);
      end

      if (ends) begin
        row = (int'(row) + 1 >= lines) ? 12'h000 : row + 12'h001;
        phase = PH_LEN_HI;
        column = '0;
        low_seen = '0;
        run_count = '0;
        line_err = ST_OK;
        bytes_left = '0;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= 10) $display("beat with nothing expected: %p", got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_a !== want.pixel_a || got.pixel_b !== want.pixel_b ||
          got.pixel_c !== want.pixel_c || got.pixel_d !== want.pixel_d ||
          got.pixel_count !== want.pixel_count || got.first_column !== want.first_column ||
          got.row_index !== want.row_index || got.end_of_line !== want.end_of_line ||
          got.end_of_image !== want.end_of_image || got.status !== want.status ||
          got.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= 10) $display("beat mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] pixel_a, pixel_b, pixel_c, pixel_d;
  logic [2:0]  pixel_count;
  logic [11:0] first_column, row_index;
  logic        end_of_line, end_of_image, last_of_run;
  logic [2:0]  status;

  line_decode_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned bytes_sent = 0;
  int unsigned width_now = LINE_WIDTH_RESET;

  split_plane_rle_image_decoder #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_LINES(MAX_LINES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_a(pixel_a),
    .pixel_b(pixel_b),
    .pixel_c(pixel_c),
    .pixel_d(pixel_d),
    .pixel_count(pixel_count),
    .first_column(first_column),
    .row_index(row_index),
    .end_of_line(end_of_line),
    .end_of_image(end_of_image),
    .status(status),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("split_plane_rle_image_decoder regression: fail");
    $finish;
  end

  // Output side: checks each accepted beat and drives ready, including the long hold-off.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({pixel_a, pixel_b, pixel_c, pixel_d, pixel_count, first_column,
                       row_index, end_of_line, end_of_image, status, last_of_run});
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line(input bytes_t body);
    int unsigned len;
    len = body.size() + 2;
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic send_bad_length(input logic [7:0] lo);
    send_byte(8'h00);
    send_byte(lo);
  endtask

  // Stops offering bytes until every owed beat is back, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    if (idx == REG_LINE_WIDTH) width_now = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(input logic [12:0] w, input logic [12:0] n);
    write_register(REG_LINE_WIDTH, w);
    write_register(REG_LINE_COUNT, n);
  endtask

  // Builds one line body: mostly well-formed, the rest short, overfilled, odd or noise.
  function automatic void make_line(input int unsigned w, output bytes_t body);
    int unsigned kind, target, placed, cap, n;
    body = {};
    kind = $urandom_range(99, 0);
    if (kind < 5) begin
      n = $urandom_range(w - 1, 0);
      repeat (n) body.push_back(8'($urandom_range(255, 0)));
      return;
    end
    if (kind < 10) begin
      n = $urandom_range(2 * w + 8, 0);
      repeat (n) body.push_back(8'($urandom_range(255, 0)));
      return;
    end
    repeat (w) body.push_back(8'($urandom_range(255, 0)));
    target = (kind < 20) ? $urandom_range(w - 1, 0) : w;
    case ($urandom_range(2, 0))
      0: cap = 4;
      1: cap = 16;
      default: cap = 255;
    endcase
    placed = 0;
    while (placed < target) begin
      n = $urandom_range((target - placed < cap) ? target - placed : cap, 0);
      body.push_back(8'(n));
      body.push_back(8'($urandom_range(255, 0)));
      placed += n;
    end
    if (kind >= 20 && kind < 30) begin
      body.push_back(8'($urandom_range(255, 1)));
      body.push_back(8'($urandom_range(255, 0)));
    end else if (kind >= 30 && kind < 38) begin
      body.push_back(8'($urandom_range(255, 0)));
    end
  endfunction

  initial begin : stimulus
    bytes_t      body;
    int unsigned first_mark, r, w, n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_shape(13'd4, 13'd3);
    body = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'd3, 8'hFF, 8'd1, 8'h00};
    send_line(body);
    // An empty run in the middle of the line.
    body = '{8'h11, 8'h22, 8'h33, 8'h44, 8'd0, 8'h12, 8'd4, 8'h80};
    send_line(body);
    // The closing run places nothing, so only a status beat marks the line end.
    body = '{8'h01, 8'h02, 8'h03, 8'h04, 8'd4, 8'h01, 8'd0, 8'h33};
    send_line(body);
    body = '{8'h10, 8'h20, 8'h30, 8'h40, 8'd3, 8'h7F, 8'd5, 8'hC0};
    send_line(body);
    body = '{8'h66, 8'h77, 8'h88, 8'h99, 8'd2, 8'h40};
    send_line(body);
    body = '{8'hAA, 8'h55};
    send_line(body);
    body = '{8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'd4, 8'h01, 8'd7};
    send_line(body);
    body = {};
    send_line(body);
    send_bad_length(8'h00);
    send_bad_length(8'h01);

    // Lower the line count once the row is already past it: the next line ends the image.
    set_shape(13'd4, 13'd6);
    while (sb.row < 4) begin
      make_line(4, body);
      send_line(body);
    end
    write_register(REG_LINE_COUNT, 13'd2);
    make_line(4, body);
    send_line(body);

    // A full line of runs while the output is held off, so the block backs up into its input.
    set_shape(13'd32, 13'd8);
    body = {};
    repeat (32) body.push_back(8'($urandom_range(255, 0)));
    repeat (4) begin
      body.push_back(8'd8);
      body.push_back(8'($urandom_range(255, 0)));
    end
    hold_len = 400;
    send_line(body);

    set_shape(13'd1, 13'd1);
    body = '{8'h7E, 8'd1, 8'hFF};
    send_line(body);
    body = '{8'h81, 8'd0, 8'h01};
    send_line(body);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      first_mark = bytes_sent;
      while (bytes_sent - first_mark < 25) begin
        if (bytes_sent == first_mark || $urandom_range(99, 0) < 8) begin
          r = $urandom_range(99, 0);
          w = (r < 75) ? $urandom_range(12, 1) :
              (r < 95) ? $urandom_range(24, 13) : $urandom_range(40, 25);
          n = ($urandom_range(9, 0) == 0) ? 4096 : $urandom_range(8, 1);
          set_shape(13'(w), 13'(n));
        end
        if ($urandom_range(99, 0) < 3) begin
          send_bad_length(8'($urandom_range(1, 0)));
        end else begin
          make_line(width_now, body);
          send_line(body);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.failures += sb.pending();
    if (sb.failures == 0)
      $display("split_plane_rle_image_decoder regression: pass");
    else
      $display("split_plane_rle_image_decoder regression: fail");
    $finish;
  end

endmodule

// ===== split_plane_rle_image_decoder.f =====
hdl/sprle_pkg.sv
hdl/split_plane_rle_image_decoder.sv
tb/sv/testbench.sv
